// ===== src/glt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the glyph lookup and text layout block.
// No dependencies; imported by glyph_lookup_text_layout.
package glt_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;

    // Stream payload widths (byte padded)
    localparam int IN_TDATA_W  = 88;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 72;
    localparam int OUT_TUSER_W = 1;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH = 2'd2;

    localparam logic [10:0] RST_GLYPH_COUNT  = 11'd0;
    localparam logic [7:0]  RST_LINE_HEIGHT  = 8'd16;
    localparam logic [9:0]  RST_SCREEN_WIDTH = 10'd256;

    // Operation codes carried in tuser
    localparam logic [1:0] FUNC_LOAD_CODE  = 2'd0;
    localparam logic [1:0] FUNC_LOAD_WIDTH = 2'd1;
    localparam logic [1:0] FUNC_START_LINE = 2'd2;
    localparam logic [1:0] FUNC_CHAR       = 2'd3;

    localparam logic [15:0] NEWLINE_CODE = 16'h000A;

    typedef logic signed [25:0] t_alu_word;

    // Clamp an adder result to the signed 16-bit cursor range
    function automatic logic signed [15:0] sat16(input t_alu_word v);
        logic signed [15:0] r;
        if (v > 26'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -26'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// ===== src/glyph_lookup_text_layout.sv =====
`timescale 1ns / 1ps
// Top level of the glyph lookup and text layout engine: tables, search sequencer, cursor math.
// Depends on glt_pkg.

// One transaction in gives one transaction out. Table loads and start-line items go from
// accept straight to ST_DONE. A character runs binary-search probes (about 11 probes at
// 1024 loaded glyphs), each a registered code-table read and a compare, then, if that
// fails, a linear fallback over up to glyph_count entries; then a width-table read and
// ST_ACC, ST_Y (newline) or ST_ACC, ST_X1, ST_WRAP, ST_Y (on wrap only), ST_GW through the
// single shared adder, and ST_DONE hands over the result. The input is not ready while an
// item is in work; a finished result waits in the output register while the next item is
// accepted. Tables hold garbage until loaded; glyph_count must cover only loaded entries.
module glyph_lookup_text_layout (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // tdata: table_slot[9:0], char_code[25:10], bearing_left[33:26], glyph_width[41:34],
    //        advance_width[49:42], origin_x[65:50], origin_y[81:66], zero pad
    input  logic [glt_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // tuser: func[1:0]
    input  logic [glt_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: glyph_slot[9:0], draw_x[25:10], draw_y[41:26], width_total[65:42], zero pad
    output logic [glt_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // tuser: draw_valid[0]
    output logic [glt_pkg::OUT_TUSER_W-1:0]  m_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic                             i_cfg_we,
    input  logic [glt_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [glt_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import glt_pkg::*;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_BS_RD   = 4'd1;
    localparam logic [3:0] ST_BS_CMP  = 4'd2;
    localparam logic [3:0] ST_LIN_RD  = 4'd3;
    localparam logic [3:0] ST_LIN_CMP = 4'd4;
    localparam logic [3:0] ST_W_RD    = 4'd5;
    localparam logic [3:0] ST_ACC     = 4'd6;
    localparam logic [3:0] ST_X1      = 4'd7;
    localparam logic [3:0] ST_WRAP    = 4'd8;
    localparam logic [3:0] ST_Y       = 4'd9;
    localparam logic [3:0] ST_GW      = 4'd10;
    localparam logic [3:0] ST_DONE    = 4'd11;

    // Input field unpack
    logic [9:0]         in_slot;
    logic [15:0]        in_code;
    logic [7:0]         in_bearing;
    logic [7:0]         in_gwidth;
    logic [7:0]         in_adv;
    logic signed [15:0] in_ox;
    logic signed [15:0] in_oy;
    logic [1:0]         in_func;

    assign in_slot    = s_axis_tdata[9:0];
    assign in_code    = s_axis_tdata[25:10];
    assign in_bearing = s_axis_tdata[33:26];
    assign in_gwidth  = s_axis_tdata[41:34];
    assign in_adv     = s_axis_tdata[49:42];
    assign in_ox      = s_axis_tdata[65:50];
    assign in_oy      = s_axis_tdata[81:66];
    assign in_func    = s_axis_tuser[1:0];

    logic [3:0]         r_state;
    logic [10:0]        r_glyph_count;
    logic [7:0]         r_line_height;
    logic [9:0]         r_screen_width;
    logic [15:0]        r_code;
    logic               r_is_nl;
    logic [CNT_W-1:0]   r_lo;
    logic [CNT_W-1:0]   r_hi;
    logic [IDX_W-1:0]   r_glyph;
    logic signed [15:0] r_cursor_x;
    logic signed [15:0] r_cursor_y;
    logic signed [15:0] r_origin_x;
    logic [23:0]        r_accum;
    logic signed [15:0] r_dx;
    logic signed [15:0] r_dy;
    logic               r_dvalid;
    logic [15:0]        r_code_q;
    logic [23:0]        r_wt_q;
    logic               r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic               r_out_user;

    logic [15:0] code_table [TABLE_DEPTH];
    logic [23:0] width_table [TABLE_DEPTH];

    logic             in_accept;
    logic             out_free;
    logic             slot_ok;
    logic [CNT_W-1:0] n_lim;
    logic [CNT_W-1:0] mid;
    logic [IDX_W-1:0] rd_addr;
    t_alu_word        alu_a;
    t_alu_word        alu_b;
    t_alu_word        alu_sum;
    logic signed [15:0] alu_sat;

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign out_free      = !r_out_valid || m_axis_tready;
    assign slot_ok       = 32'(in_slot) < TABLE_DEPTH;

    // Searchable entries: glyph_count clamped to the table depth
    always_comb begin
        if (32'(r_glyph_count) > TABLE_DEPTH) begin
            n_lim = CNT_W'(TABLE_DEPTH);
        end else begin
            n_lim = CNT_W'(r_glyph_count);
        end
    end

    // Binary search midpoint; lo <= hi holds whenever it is used
    assign mid     = r_lo + ((r_hi - r_lo) >> 1);
    assign rd_addr = (r_state == ST_BS_RD) ? mid[IDX_W-1:0] : r_lo[IDX_W-1:0];

    // Shared adder operand select
    always_comb begin
        alu_a = '0;
        alu_b = '0;
        case (r_state)
            ST_ACC: begin
                alu_a = {2'b00, r_accum};
                alu_b = {18'd0, r_wt_q[23:16]};
            end
            ST_X1: begin
                alu_a = 26'(r_cursor_x);
                alu_b = {18'd0, r_wt_q[7:0]};
            end
            ST_WRAP: begin
                alu_a = 26'(r_origin_x);
                alu_b = {18'd0, r_wt_q[7:0]};
            end
            ST_Y: begin
                alu_a = 26'(r_cursor_y);
                alu_b = {18'd0, r_line_height};
            end
            ST_GW: begin
                alu_a = 26'(r_cursor_x);
                alu_b = {18'd0, r_wt_q[15:8]};
            end
            default: begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end

    assign alu_sum = alu_a + alu_b;
    assign alu_sat = sat16(alu_sum);

    // Table writes and registered reads
    always_ff @(posedge i_clk) begin
        if (in_accept && slot_ok && in_func == FUNC_LOAD_CODE) begin
            code_table[IDX_W'(in_slot)] <= in_code;
        end
        if (in_accept && slot_ok && in_func == FUNC_LOAD_WIDTH) begin
            width_table[IDX_W'(in_slot)] <= {in_adv, in_gwidth, in_bearing};
        end
        r_code_q <= code_table[rd_addr];
        r_wt_q   <= width_table[r_glyph];
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glyph_count  <= RST_GLYPH_COUNT;
            r_line_height  <= RST_LINE_HEIGHT;
            r_screen_width <= RST_SCREEN_WIDTH;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_GLYPH_COUNT:  r_glyph_count  <= i_cfg_data[10:0];
                REG_LINE_HEIGHT:  r_line_height  <= i_cfg_data[7:0];
                REG_SCREEN_WIDTH: r_screen_width <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // Sequencer and cursor state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_cursor_x <= '0;
            r_cursor_y <= '0;
            r_origin_x <= '0;
            r_accum    <= '0;
            r_dvalid   <= 1'b0;
            r_glyph    <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        r_code   <= in_code;
                        r_is_nl  <= (in_code == NEWLINE_CODE);
                        r_dvalid <= 1'b0;
                        r_glyph  <= '0;
                        r_lo     <= '0;
                        r_hi     <= n_lim - CNT_W'(1);
                        if (in_func == FUNC_START_LINE) begin
                            r_origin_x <= in_ox;
                            r_cursor_x <= in_ox;
                            r_cursor_y <= in_oy;
                            r_accum    <= '0;
                        end
                        if (in_func != FUNC_CHAR) begin
                            r_state <= ST_DONE;
                        end else if (n_lim == '0) begin
                            r_state <= ST_W_RD;
                        end else begin
                            r_state <= ST_BS_RD;
                        end
                    end
                end
                ST_BS_RD: begin
                    r_state <= ST_BS_CMP;
                end
                ST_BS_CMP: begin
                    if (r_code_q == r_code) begin
                        r_glyph <= mid[IDX_W-1:0];
                        r_state <= ST_W_RD;
                    end else if (r_code_q < r_code) begin
                        if (mid == r_hi) begin
                            r_lo    <= '0;
                            r_state <= ST_LIN_RD;
                        end else begin
                            r_lo    <= mid + CNT_W'(1);
                            r_state <= ST_BS_RD;
                        end
                    end else begin
                        if (mid == r_lo) begin
                            r_lo    <= '0;
                            r_state <= ST_LIN_RD;
                        end else begin
                            r_hi    <= mid - CNT_W'(1);
                            r_state <= ST_BS_RD;
                        end
                    end
                end
                ST_LIN_RD: begin
                    r_state <= ST_LIN_CMP;
                end
                ST_LIN_CMP: begin
                    if (r_code_q == r_code) begin
                        r_glyph <= r_lo[IDX_W-1:0];
                        r_state <= ST_W_RD;
                    end else if (r_lo + CNT_W'(1) == n_lim) begin
                        r_glyph <= '0;
                        r_state <= ST_W_RD;
                    end else begin
                        r_lo    <= r_lo + CNT_W'(1);
                        r_state <= ST_LIN_RD;
                    end
                end
                ST_W_RD: begin
                    r_state <= ST_ACC;
                end
                ST_ACC: begin
                    // running advance total, saturating at 24 bits
                    if (alu_sum[25:24] != 2'b00) begin
                        r_accum <= '1;
                    end else begin
                        r_accum <= alu_sum[23:0];
                    end
                    if (r_is_nl) begin
                        r_cursor_x <= r_origin_x;
                        r_state    <= ST_Y;
                    end else begin
                        r_state <= ST_X1;
                    end
                end
                ST_X1: begin
                    r_cursor_x <= alu_sat;
                    r_state    <= ST_WRAP;
                end
                ST_WRAP: begin
                    // wrap when x passes the screen edge
                    if (17'(r_cursor_x) > $signed({7'd0, r_screen_width})) begin
                        r_cursor_x <= alu_sat;
                        r_state    <= ST_Y;
                    end else begin
                        r_state <= ST_GW;
                    end
                end
                ST_Y: begin
                    r_cursor_y <= alu_sat;
                    r_state    <= r_is_nl ? ST_DONE : ST_GW;
                end
                ST_GW: begin
                    r_dx       <= r_cursor_x;
                    r_dy       <= r_cursor_y;
                    r_dvalid   <= 1'b1;
                    r_cursor_x <= alu_sat;
                    r_state    <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Output register: holds a result until the downstream transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            r_out_data <= {6'd0, r_accum,
                           r_dvalid ? r_dy : r_cursor_y,
                           r_dvalid ? r_dx : r_cursor_x,
                           10'(r_glyph)};
            r_out_user <= r_dvalid;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_data;
    assign m_axis_tuser[0] = r_out_user;

    // Checks on the search sequencer
    a_bs_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_BS_RD) |-> (r_lo <= r_hi && r_hi < n_lim))
        else $error("binary search bounds out of order");

    a_lin_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LIN_RD) |-> (r_lo < n_lim))
        else $error("linear scan index past glyph count");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state != ST_IDLE))
        else $error("sequencer idle right after an accepted item");

    a_result_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && out_free) |=> (m_axis_tvalid && r_state == ST_IDLE))
        else $error("finished item did not reach the output register");

endmodule
